/* hw/rtl/ales_pkg.sv */
// ----------------------------------------------------------------------------
// ales_pkg
// shared types and constants of the adjacency list edge store
// ----------------------------------------------------------------------------
package ales_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int MAX_EDGES    = 64;

  localparam int VTX_W  = 4;
  localparam int NODE_W = $clog2(MAX_EDGES);
  localparam int USED_W = $clog2(MAX_EDGES + 1);
  localparam int VCNT_W = 5;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [ADDR_W-1:0] REG_VERTEX_COUNT = ADDR_W'(0);
  localparam logic [VCNT_W-1:0] VERTEX_COUNT_RESET = VCNT_W'(16);

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    ACTION_APPEND = 1'b0,
    ACTION_QUERY  = 1'b1
  } action_t;

  typedef struct packed {
    logic             action;
    logic [VTX_W-1:0] vertex;
    logic [VTX_W-1:0] neighbor;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] next;
    logic              has_next;
  } link_t;

endpackage

/* hw/rtl/adjacency_list_edge_store.sv */
// ----------------------------------------------------------------------------
// adjacency_list_edge_store
// per-vertex neighbor lists in a shared node pool with append and search
// ----------------------------------------------------------------------------
// One item is handled at a time. An append writes the new node in S_APPEND
// and then goes to S_RESULT; when the list already has nodes, S_LINK comes
// between them and relinks the old tail node. A query on a non-empty list
// reads the head node in S_HEAD_RD, then S_WALK visits up to MAX_EDGES nodes
// and stops on a hit: the walk reads one node per cycle from the single read
// port of the node memory. A query on an empty list, a rejected index or a
// full pool goes straight to S_RESULT. The next item is taken once the result
// sits in the output register, even while it is stalled.
module adjacency_list_edge_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ales_pkg::ADDR_W-1:0] paddr,
  input  logic [ales_pkg::DATA_W-1:0] pwdata,
  output logic [ales_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ales_pkg::in_item_t        in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ales_pkg::out_item_t       out_item
);
  import ales_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_LINK,
    S_HEAD_RD,
    S_WALK,
    S_RESULT
  } state_t;

  state_t state;

  logic [VCNT_W-1:0] vertex_count;
  logic [USED_W-1:0] nodes_used;
  logic [MAX_VERTICES-1:0] list_nonempty;
  logic [NODE_W-1:0] list_head [MAX_VERTICES];
  logic [NODE_W-1:0] list_tail [MAX_VERTICES];

  logic [VTX_W-1:0] nb_mem [MAX_EDGES];
  link_t            lk_mem [MAX_EDGES];
  logic [VTX_W-1:0] nb_rd;
  link_t            lk_rd;

  logic [VTX_W-1:0]  vertex_r;
  logic [VTX_W-1:0]  neighbor_r;
  logic [NODE_W-1:0] steps;
  logic              res_found;
  status_t           res_status;

  logic              in_accept;
  logic              cfg_write;
  logic              vertex_ok;
  logic              neighbor_ok;
  logic              pool_full;
  logic [NODE_W-1:0] new_node;
  logic              walk_hit;
  logic              walk_end;
  logic              rd_en;
  logic [NODE_W-1:0] rd_addr;
  logic              lk_we;
  logic [NODE_W-1:0] lk_waddr;
  link_t             lk_wdata;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == REG_VERTEX_COUNT) ? DATA_W'(vertex_count) : '0;

  // handshake
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign vertex_ok   = (32'(in_item.vertex) < 32'(vertex_count)) &&
                       (32'(in_item.vertex) < MAX_VERTICES);
  assign neighbor_ok = (32'(in_item.neighbor) < 32'(vertex_count)) &&
                       (32'(in_item.neighbor) < MAX_VERTICES);
  assign pool_full   = (nodes_used == USED_W'(MAX_EDGES));
  assign new_node    = nodes_used[NODE_W-1:0];

  // list walk
  assign walk_hit = (nb_rd == neighbor_r);
  assign walk_end = !lk_rd.has_next || (steps == NODE_W'(MAX_EDGES - 1));
  assign rd_en    = (state == S_HEAD_RD) || ((state == S_WALK) && !walk_hit && !walk_end);
  assign rd_addr  = (state == S_HEAD_RD) ? list_head[vertex_r] : lk_rd.next;

  // link memory write port
  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = new_node;
    lk_wdata = '{next: '0, has_next: 1'b0};
    case (state)
      S_APPEND: begin
        lk_we = 1'b1;
      end
      S_LINK: begin
        lk_we    = 1'b1;
        lk_waddr = list_tail[vertex_r];
        lk_wdata = '{next: new_node, has_next: 1'b1};
      end
      default: begin
        lk_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_APPEND) begin
      nb_mem[new_node] <= neighbor_r;
    end
    if (lk_we) begin
      lk_mem[lk_waddr] <= lk_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      nb_rd <= nb_mem[rd_addr];
      lk_rd <= lk_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_APPEND && !list_nonempty[vertex_r]) begin
      list_head[vertex_r] <= new_node;
      list_tail[vertex_r] <= new_node;
    end
    if (state == S_LINK) begin
      list_tail[vertex_r] <= new_node;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      vertex_count  <= VERTEX_COUNT_RESET;
      nodes_used    <= '0;
      list_nonempty <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write && paddr == REG_VERTEX_COUNT) begin
        vertex_count <= pwdata[VCNT_W-1:0];
      end
      // output register
      if (state == S_RESULT && (!out_valid || !out_stall)) begin
        out_valid       <= 1'b1;
        out_item.found  <= res_found;
        out_item.status <= res_status;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            vertex_r   <= in_item.vertex;
            neighbor_r <= in_item.neighbor;
            steps      <= '0;
            res_found  <= 1'b0;
            if (!vertex_ok || !neighbor_ok) begin
              res_status <= STATUS_RANGE;
              state      <= S_RESULT;
            end else if (in_item.action == ACTION_APPEND) begin
              if (pool_full) begin
                res_status <= STATUS_FULL;
                state      <= S_RESULT;
              end else begin
                res_status <= STATUS_OK;
                state      <= S_APPEND;
              end
            end else if (list_nonempty[in_item.vertex]) begin
              res_status <= STATUS_OK;
              state      <= S_HEAD_RD;
            end else begin
              res_status <= STATUS_OK;
              state      <= S_RESULT;
            end
          end
        end
        S_APPEND: begin
          if (list_nonempty[vertex_r]) begin
            state <= S_LINK;
          end else begin
            list_nonempty[vertex_r] <= 1'b1;
            nodes_used              <= nodes_used + USED_W'(1);
            state                   <= S_RESULT;
          end
        end
        S_LINK: begin
          nodes_used <= nodes_used + USED_W'(1);
          state      <= S_RESULT;
        end
        S_HEAD_RD: begin
          state <= S_WALK;
        end
        S_WALK: begin
          if (walk_hit) begin
            res_found <= 1'b1;
            state     <= S_RESULT;
          end else if (walk_end) begin
            state <= S_RESULT;
          end else begin
            steps <= steps + NODE_W'(1);
          end
        end
        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= USED_W'(MAX_EDGES))
    else $error("node pool count above pool size");

  a_link_needs_list: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK || state == S_WALK) |-> list_nonempty[vertex_r])
    else $error("tail relink or walk on an empty list");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == STATUS_FULL |-> pool_full)
    else $error("pool full reported with free nodes");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.found |-> out_item.status == STATUS_OK)
    else $error("found set with error status");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_LINK |=> nodes_used == $past(nodes_used) + USED_W'(1))
    else $error("relink did not allocate a node");
`endif

endmodule
